// ===== rtl/cpid_pkg.sv =====
`timescale 1ns / 1ps
package cpid_pkg;
	localparam int GAIN_W = 28;
	localparam int SIG_W  = 24;
	localparam int ERR_W  = 26;
	localparam int OPD_W  = 27;
	localparam int ACC_W  = 58;
	localparam int DRV_W  = 16;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 3;
	localparam int MODE_W = 2;

	localparam int WRAP_LIMIT  = 46054;
	localparam int FULL_TURN   = 92160;
	localparam int INTEG_LIMIT = 6400000;
	localparam int TIGHT_INTEG = 2560000;
	localparam int OUT_LIMIT   = 30000;
	localparam int TIGHT_LIMIT = 10000;

	localparam logic [IDX_W-1:0] REG_OUTER_KP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_OUTER_KI  = 3'd1;
	localparam logic [IDX_W-1:0] REG_OUTER_KD  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INNER_KP  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INNER_KI  = 3'd4;
	localparam logic [IDX_W-1:0] REG_INNER_KD  = 3'd5;
	localparam logic [IDX_W-1:0] REG_LOOP_MODE = 3'd6;

	localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TIGHT = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;
endpackage

// ===== rtl/cpid_if.sv =====
`timescale 1ns / 1ps
interface cpid_in_if import cpid_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SIG_W-1:0] target_angle;
	logic signed [SIG_W-1:0] measured_angle;
	logic signed [SIG_W-1:0] measured_rate;
	modport source (output valid, target_angle, measured_angle, measured_rate, input ready);
	modport sink (input valid, target_angle, measured_angle, measured_rate, output ready);
endinterface

interface cpid_out_if import cpid_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SIG_W-1:0] rate_command;
	logic signed [DRV_W-1:0] drive;
	modport source (output valid, rate_command, drive, input ready);
	modport sink (input valid, rate_command, drive, output ready);
endinterface

interface cpid_cfg_if import cpid_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] index;
	logic [GAIN_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cascaded_angle_rate_pid_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                      Beat when
// cmd_in    in   target_angle, measured_angle, measured_rate  valid && ready
// res_out   out  rate_command, drive                          valid && ready
// cfg       in   index (register), data                       valid && ready
//
// A tick from input beat to result is six serial products (one gain bit per
// cycle in the shared MAC) plus sequencing.
// Reset clears gains, mode, integrals and last errors.
// A result waits in the output register; the next input beat is taken while
// it waits, and a finished tick holds until that register is free.
module cascaded_angle_rate_pid_core import cpid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cpid_in_if.sink    cmd_in,
	cpid_out_if.source res_out,
	cpid_cfg_if.sink   cfg
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OERR = 3'd1;
	localparam logic [2:0] S_IERR = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_SAT  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	localparam logic signed [ACC_W-1:0] OUT_LIM_Q24   = ACC_W'(OUT_LIMIT) << 24;
	localparam logic signed [ACC_W-1:0] TIGHT_LIM_Q24 = ACC_W'(TIGHT_LIMIT) << 24;

	logic [2:0] state_q;
	logic [1:0] term_q;
	logic       inner_q;

	// configuration
	logic [GAIN_W-1:0] okp_q, oki_q, okd_q, ikp_q, iki_q, ikd_q;
	logic [MODE_W-1:0] mode_q;

	// tick working set
	logic signed [SIG_W-1:0] tgt_q, ang_q, rate_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [SIG_W-1:0] cmd_q;
	logic signed [DRV_W-1:0] drv_q;

	// loop state
	logic signed [SIG_W-1:0] ointeg_q, iinteg_q;
	logic signed [ERR_W-1:0] olast_q, ilast_q;

	// output register
	logic                    out_valid_q;
	logic signed [SIG_W-1:0] out_cmd_q;
	logic signed [DRV_W-1:0] out_drv_q;

	logic tight, wrap_en;
	assign tight   = (mode_q == MODE_TIGHT);
	assign wrap_en = (mode_q == MODE_WRAP)
		&& (tgt_q <= SIG_W'(WRAP_LIMIT)) && (tgt_q >= -SIG_W'(WRAP_LIMIT));

	// outer error with optional fold by a full turn
	logic signed [ERR_W-1:0] oerr_raw, oerr;
	always_comb begin
		oerr_raw = ERR_W'(tgt_q) - ERR_W'(ang_q);
		oerr = oerr_raw;
		if (wrap_en) begin
			if (oerr_raw > ERR_W'(WRAP_LIMIT))
				oerr = oerr_raw - ERR_W'(FULL_TURN);
			else if (oerr_raw < -ERR_W'(WRAP_LIMIT))
				oerr = oerr_raw + ERR_W'(FULL_TURN);
		end
	end

	logic signed [ERR_W-1:0] ierr;
	assign ierr = ERR_W'(cmd_q) - ERR_W'(rate_q);

	// integral update; one shared adder/clamp for both loops
	logic signed [ERR_W-1:0] integ_err;
	logic signed [SIG_W-1:0] integ_old, integ_new;
	logic signed [OPD_W-1:0] integ_sum, integ_lim;
	always_comb begin
		integ_err = (state_q == S_OERR) ? oerr : ierr;
		integ_old = (state_q == S_OERR) ? ointeg_q : iinteg_q;
		integ_lim = (state_q == S_IERR && tight) ? OPD_W'(TIGHT_INTEG) : OPD_W'(INTEG_LIMIT);
		integ_sum = OPD_W'(integ_old) + OPD_W'(integ_err);
		if (integ_sum > integ_lim)
			integ_new = SIG_W'(integ_lim);
		else if (integ_sum < -integ_lim)
			integ_new = SIG_W'(-integ_lim);
		else
			integ_new = integ_sum[SIG_W-1:0];
	end

	// MAC operand/gain select per term: p, i, d
	logic signed [SIG_W-1:0] cur_integ;
	logic signed [ERR_W-1:0] cur_last;
	logic signed [OPD_W-1:0] mac_opd;
	logic [GAIN_W-1:0]       mac_gain;
	always_comb begin
		cur_integ = inner_q ? iinteg_q : ointeg_q;
		cur_last  = inner_q ? ilast_q : olast_q;
		case (term_q)
			TERM_P: begin
				mac_opd  = OPD_W'(err_q);
				mac_gain = inner_q ? ikp_q : okp_q;
			end
			TERM_I: begin
				mac_opd  = OPD_W'(cur_integ);
				mac_gain = inner_q ? iki_q : oki_q;
			end
			default: begin
				mac_opd  = OPD_W'(err_q) - OPD_W'(cur_last);
				mac_gain = inner_q ? ikd_q : okd_q;
			end
		endcase
	end

	mac_ctrl_t               mac_ctrl;
	mac_stat_t               mac_st;
	logic signed [ACC_W-1:0] mac_acc;
	assign mac_ctrl.start = (state_q == S_LOAD);
	assign mac_ctrl.clear = (term_q == TERM_P);

	cpid_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.gain    (mac_gain),
		.operand (mac_opd),
		.stat    (mac_st),
		.acc     (mac_acc)
	);

	// output saturation and truncation toward zero
	logic signed [ACC_W-1:0] lim, sat, cmd_sh, drv_sh;
	always_comb begin
		lim = tight ? TIGHT_LIM_Q24 : OUT_LIM_Q24;
		if (mac_acc > lim)
			sat = lim;
		else if (mac_acc < -lim)
			sat = -lim;
		else
			sat = mac_acc;
		cmd_sh = sat[ACC_W-1] ? ((sat + ACC_W'(16'hFFFF)) >>> 16) : (sat >>> 16);
		drv_sh = sat[ACC_W-1] ? ((sat + ACC_W'(24'hFFFFFF)) >>> 24) : (sat >>> 24);
	end

	logic in_beat, out_beat, out_load;
	assign cmd_in.ready = (state_q == S_IDLE);
	assign in_beat  = cmd_in.valid && cmd_in.ready;
	assign out_beat = res_out.valid && res_out.ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || res_out.ready);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			okp_q <= '0; oki_q <= '0; okd_q <= '0;
			ikp_q <= '0; iki_q <= '0; ikd_q <= '0;
			mode_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_OUTER_KP:  okp_q  <= cfg.data;
				REG_OUTER_KI:  oki_q  <= cfg.data;
				REG_OUTER_KD:  okd_q  <= cfg.data;
				REG_INNER_KP:  ikp_q  <= cfg.data;
				REG_INNER_KI:  iki_q  <= cfg.data;
				REG_INNER_KD:  ikd_q  <= cfg.data;
				REG_LOOP_MODE: mode_q <= cfg.data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= '0;
			inner_q     <= 1'b0;
			ointeg_q    <= '0;
			iinteg_q    <= '0;
			olast_q     <= '0;
			ilast_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace one leaving in the same cycle
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_beat)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_beat) state_q <= S_OERR;
				S_OERR: begin
					ointeg_q <= integ_new;
					inner_q  <= 1'b0;
					term_q   <= TERM_P;
					state_q  <= S_LOAD;
				end
				S_IERR: begin
					iinteg_q <= integ_new;
					inner_q  <= 1'b1;
					term_q   <= TERM_P;
					state_q  <= S_LOAD;
				end
				S_LOAD: state_q <= S_WAIT;
				S_WAIT: if (mac_st.done) begin
					if (term_q == TERM_D) begin
						state_q <= S_SAT;
					end else begin
						term_q  <= term_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_SAT: begin
					if (inner_q) begin
						ilast_q <= err_q;
						state_q <= S_OUT;
					end else begin
						olast_q <= err_q;
						state_q <= S_IERR;
					end
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			tgt_q  <= cmd_in.target_angle;
			ang_q  <= cmd_in.measured_angle;
			rate_q <= cmd_in.measured_rate;
		end
		if (state_q == S_OERR)
			err_q <= oerr;
		if (state_q == S_IERR)
			err_q <= ierr;
		if (state_q == S_SAT) begin
			if (inner_q)
				drv_q <= drv_sh[DRV_W-1:0];
			else
				cmd_q <= cmd_sh[SIG_W-1:0];
		end
		if (out_load) begin
			out_cmd_q <= cmd_q;
			out_drv_q <= drv_q;
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.rate_command = out_cmd_q;
	assign res_out.drive        = out_drv_q;

	a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_st.done |-> (state_q == S_WAIT))
		else $error("MAC finished outside wait state");
	a_mac_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_st.busy |-> (state_q == S_WAIT))
		else $error("MAC running outside wait state");
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !cmd_in.ready)
		else $error("input taken while tick in flight");
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ointeg_q <= SIG_W'(INTEG_LIMIT)) && (ointeg_q >= -SIG_W'(INTEG_LIMIT))
		&& (iinteg_q <= SIG_W'(INTEG_LIMIT)) && (iinteg_q >= -SIG_W'(INTEG_LIMIT)))
		else $error("integral out of range");
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.drive <= DRV_W'(OUT_LIMIT))
		&& (res_out.drive >= -DRV_W'(OUT_LIMIT)))
		else $error("drive out of range");
endmodule

// ===== rtl/cpid_mac.sv =====
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: one gain bit per cycle, shift-add into acc.
module cpid_mac import cpid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctrl_t                ctrl,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [OPD_W-1:0]  operand,
	output mac_stat_t                stat,
	output logic signed [ACC_W-1:0]  acc
);
	logic [GAIN_W-1:0]       g_q;
	logic signed [ACC_W-1:0] m_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			g_q <= gain;
			m_q <= ACC_W'(operand);
			if (ctrl.clear)
				acc_q <= '0;
		end else if (busy_q) begin
			if (g_q[0])
				acc_q <= acc_q + m_q;
			g_q <= g_q >> 1;
			m_q <= m_q <<< 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;
endmodule

// ===== dv/cascaded_angle_rate_pid_core_test.sv =====
`timescale 1ns / 1ps
module cascaded_angle_rate_pid_core_test;
	import cpid_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	// Everything the loops compute is held in 64-bit integers; the widest
	// product is a 28-bit gain times a 27-bit error, which fits with margin.
	typedef struct {
		logic signed [SIG_W-1:0] rate_command;
		logic signed [DRV_W-1:0] drive;
	} tick_result_t;

	// Predicts each control tick and holds the results still to come.
	class pid_scoreboard;
		longint unsigned gain[7];
		logic [MODE_W-1:0] mode;
		longint angle_integ, angle_last, rate_integ, rate_last;
		tick_result_t pending[$];
		int errors;

		function void clear();
			foreach (gain[i]) gain[i] = 0;
			mode = '0;
			angle_integ = 0;
			angle_last = 0;
			rate_integ = 0;
			rate_last = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
			if (idx == REG_LOOP_MODE)
				mode = val[MODE_W-1:0];
			else if (idx < REG_LOOP_MODE)
				gain[idx] = val;
		endfunction

		function longint sat(longint v, longint lim);
			return (v > lim) ? lim : ((v < -lim) ? -lim : v);
		endfunction

		// Divide by 2^k, rounding toward zero.
		function longint shr0(longint v, int k);
			return (v < 0) ? -((-v) >>> k) : (v >>> k);
		endfunction

		function void note_tick(logic signed [SIG_W-1:0] tgt,
				logic signed [SIG_W-1:0] ang, logic signed [SIG_W-1:0] rt);
			longint t, e, acc, cmd, drv, olim, ilim;
			tick_result_t r;
			bit tight;
			t = tgt;
			tight = (mode == MODE_TIGHT);
			olim = longint'(tight ? TIGHT_LIMIT : OUT_LIMIT) <<< 24;
			ilim = tight ? TIGHT_INTEG : INTEG_LIMIT;
			e = t - longint'(ang);
			// Angle error folds by a full turn only for targets within the wrap window.
			if (mode == MODE_WRAP && t <= WRAP_LIMIT && t >= -WRAP_LIMIT) begin
				if (e > WRAP_LIMIT) e -= FULL_TURN;
				else if (e < -WRAP_LIMIT) e += FULL_TURN;
			end
			angle_integ = sat(angle_integ + e, INTEG_LIMIT);
			acc = longint'(gain[REG_OUTER_KP]) * e
				+ longint'(gain[REG_OUTER_KI]) * angle_integ
				+ longint'(gain[REG_OUTER_KD]) * (e - angle_last);
			acc = sat(acc, olim);
			angle_last = e;
			cmd = shr0(acc, 16);
			e = cmd - longint'(rt);
			rate_integ = sat(rate_integ + e, ilim);
			acc = longint'(gain[REG_INNER_KP]) * e
				+ longint'(gain[REG_INNER_KI]) * rate_integ
				+ longint'(gain[REG_INNER_KD]) * (e - rate_last);
			acc = sat(acc, olim);
			rate_last = e;
			drv = shr0(acc, 24);
			r.rate_command = cmd[SIG_W-1:0];
			r.drive = drv[DRV_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_tick(logic signed [SIG_W-1:0] cmd, logic signed [DRV_W-1:0] drv);
			tick_result_t r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat rate_command=%0d drive=%0d", $time, cmd, drv);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (cmd !== r.rate_command) begin
				$display("%0t: rate_command expected %0d actual %0d", $time, r.rate_command, cmd);
				errors++;
			end
			if (drv !== r.drive) begin
				$display("%0t: drive expected %0d actual %0d", $time, r.drive, drv);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpid_in_if  cmd_in();
	cpid_out_if res_out();
	cpid_cfg_if cfg();

	cascaded_angle_rate_pid_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_in (cmd_in.sink),
		.res_out(res_out.source),
		.cfg    (cfg.sink)
	);

	always #2 clk = ~clk;

	pid_scoreboard sb = new();

	int send_idle_pct = 0;   // sender gap odds, percent per cycle
	int recv_stall_pct = 0;  // receiver stall odds, percent per cycle
	bit recv_hold = 1'b0;    // long hold-off for back-pressure
	bit sb_ready = 1'b0;

	// Monitor: sample beats at the rising edge.
	always @(posedge clk) begin
		if (sb_ready && arst_n) begin
			if (cmd_in.valid && cmd_in.ready)
				sb.note_tick(cmd_in.target_angle, cmd_in.measured_angle, cmd_in.measured_rate);
			if (res_out.valid && res_out.ready)
				sb.check_tick(res_out.rate_command, res_out.drive);
		end
	end

	// Receiver: ready changes on the falling edge only.
	always @(negedge clk) begin
		if (recv_hold)
			res_out.ready <= 1'b0;
		else
			res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		cfg.index <= idx;
		cfg.data  <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one tick; gaps before it come from the current idle odds.
	task automatic send_tick(logic signed [SIG_W-1:0] tgt,
			logic signed [SIG_W-1:0] ang, logic signed [SIG_W-1:0] rt);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_in.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_in.target_angle   <= tgt;
		cmd_in.measured_angle <= ang;
		cmd_in.measured_rate  <= rt;
		cmd_in.valid <= 1'b1;
		do @(posedge clk); while (!cmd_in.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_in.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		// idle tail after the last result is checked
		repeat (250) @(negedge clk);
	endtask

	function automatic logic signed [SIG_W-1:0] rand_sig(int kind);
		case (kind)
			0: return SIG_W'($urandom());                                 // full range
			1: return SIG_W'($signed(24'($urandom_range(92160))) - 46080); // about one turn
			2: return SIG_W'($signed(24'($urandom_range(2048))) - 1024);   // near zero
			default: return ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain(bit wide);
		if (wide) return GAIN_W'($urandom());
		case ($urandom_range(3))
			0: return '0;
			1: return GAIN_W'($urandom_range(65536 * 4));
			2: return GAIN_W'($urandom_range(65536 / 4));
			default: return GAIN_W'($urandom_range(4096));
		endcase
	endfunction

	task automatic random_phase(int n, logic [MODE_W-1:0] m, bit wide);
		for (int i = 0; i < 6; i++) write_reg(i[IDX_W-1:0], rand_gain(wide));
		write_reg(REG_LOOP_MODE, GAIN_W'(m));
		for (int i = 0; i < n; i++) begin
			logic signed [SIG_W-1:0] t;
			t = rand_sig($urandom_range(3) == 0 ? 0 : $urandom_range(1, 3));
			send_tick(t, rand_sig($urandom_range(3)), rand_sig($urandom_range(3)));
		end
		drain();
	endtask

	initial begin
		sb.clear();
		cmd_in.valid = 1'b0;
		cmd_in.target_angle = '0;
		cmd_in.measured_angle = '0;
		cmd_in.measured_rate = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res_out.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sb_ready = 1'b1;

		// Directed: all gains zero after reset, then field extremes.
		send_tick(24'sh7fffff, 24'sh800000, 24'sh7fffff);
		send_tick(24'sh800000, 24'sh7fffff, 24'sh800000);
		drain();
		// Unity gains, plain mode, extremes drive both loops into saturation.
		for (int i = 0; i < 6; i++) write_reg(i[IDX_W-1:0], 28'h0010000);
		write_reg(REG_LOOP_MODE, GAIN_W'(MODE_PLAIN));
		send_tick(24'sh7fffff, 24'sh800000, 24'sh800000);
		send_tick(24'sh800000, 24'sh7fffff, 24'sh7fffff);
		send_tick(24'sd0, 24'sd0, 24'sd0);
		send_tick(-24'sd1, 24'sd0, 24'sd1);
		drain();
		// Wrap mode: errors just past the half turn, target at the window edges.
		write_reg(REG_LOOP_MODE, GAIN_W'(MODE_WRAP));
		send_tick(24'sd46054, -24'sd100, 24'sd0);
		send_tick(-24'sd46054, 24'sd100, 24'sd0);
		send_tick(24'sd46055, -24'sd100, 24'sd0);
		send_tick(24'sd0, 24'sd46054, 24'sd0);
		send_tick(24'sd0, -24'sd46055, 24'sd0);
		send_tick(24'sd0, 24'sd46055, 24'sd0);
		drain();
		// Tight mode with maximum gains; then the unused mode code.
		for (int i = 0; i < 6; i++) write_reg(i[IDX_W-1:0], 28'hfffffff);
		write_reg(REG_LOOP_MODE, GAIN_W'(MODE_TIGHT));
		send_tick(24'sh7fffff, 24'sd0, 24'sh800000);
		send_tick(24'sh800000, 24'sd0, 24'sh7fffff);
		send_tick(24'sd1000, 24'sd0, -24'sd1000);
		drain();
		write_reg(REG_LOOP_MODE, GAIN_W'(MODE_SPARE));
		send_tick(24'sd5000, -24'sd5000, 24'sd300);
		send_tick(-24'sd5000, 24'sd5000, -24'sd300);
		drain();
		write_reg(REG_NONE, 28'hfffffff);   // out of range index is ignored
		send_tick(24'sd256, 24'sd0, 24'sd0);
		drain();

		// Random, through the idling phases and modes.
		random_phase(300, MODE_PLAIN, 1'b0);
		send_idle_pct = 70;
		random_phase(250, MODE_WRAP, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 70;
		random_phase(250, MODE_TIGHT, 1'b0);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		random_phase(250, MODE_PLAIN, 1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(150, MODE_WRAP, 1'b1);

		// Back-pressure: receiver holds off while the sender keeps offering.
		fork
			begin
				recv_hold = 1'b1;
				repeat (1500) @(negedge clk);
				recv_hold = 1'b0;
			end
			random_phase(300, MODE_TIGHT, 1'b0);
		join

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("cascaded_angle_rate_pid_core test passed");
		else
			$display("cascaded_angle_rate_pid_core test failed");
		$finish;
	end

	// Watchdog: about 1500 ticks, bounded with a wide margin.
	initial begin
		#40ms;
		$display("cascaded_angle_rate_pid_core test failed");
		$finish;
	end
endmodule
